>>> rtl/core/parameterized_crc_engine_defines.svh
// Assertion helpers for the CRC engine.
`ifndef PARAMETERIZED_CRC_ENGINE_DEFINES_SVH
`define PARAMETERIZED_CRC_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("CRC engine check failed");

// Next-cycle implication, checked outside reset.
`define PCRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("CRC engine check failed");

`endif

>>> rtl/core/pcrc_pkg.sv
package pcrc_pkg;

   localparam int DATA_W     = 8;
   localparam int CRC_OUT_W  = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CFG_WIDTH_W = 6;

   // Register indexes, taken from paddr[4:2].
   typedef enum logic [2:0] {
      REG_CRC_WIDTH      = 3'd0,
      REG_GENERATOR_POLY = 3'd1,
      REG_INITIAL_VALUE  = 3'd2,
      REG_FINAL_XOR      = 3'd3,
      REG_REFLECT_INPUT  = 3'd4,
      REG_REFLECT_OUTPUT = 3'd5
   } csr_index_type;

   localparam logic [CFG_WIDTH_W-1:0] RST_CRC_WIDTH = 6'd32;
   localparam logic [31:0] RST_GENERATOR_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] RST_INITIAL_VALUE  = 32'hFFFF_FFFF;
   localparam logic [31:0] RST_FINAL_XOR      = 32'hFFFF_FFFF;
   localparam logic        RST_REFLECT_INPUT  = 1'b1;
   localparam logic        RST_REFLECT_OUTPUT = 1'b1;

   function automatic logic [DATA_W-1:0] reverse_byte(input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] result;
      for (int i = 0; i < DATA_W; i++) begin
         result[i] = value[DATA_W-1-i];
      end
      return result;
   endfunction

endpackage

>>> rtl/core/pcrc_req_if.sv
interface pcrc_req_if import pcrc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/core/pcrc_rsp_if.sv
interface pcrc_rsp_if import pcrc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CRC_OUT_W-1:0] crc_value;

   modport source (output valid, output crc_value, input ready);
   modport sink   (input valid, input crc_value, output ready);
endinterface

>>> rtl/core/parameterized_crc_engine.sv
// A byte accepted on req_bus is held in the input stage and folded from there; for a last
// byte the finished CRC is registered in the result register and offered on rsp_bus.
// Throughput: one byte per cycle while rsp_bus is not stalled; the eight-step fold of
// the running CRC register is the single recurrence and is combinational.
// Reset (synchronous, active high) empties both stages, closes any open
// message and restores the configuration registers to their defaults.
`include "parameterized_crc_engine_defines.svh"

module parameterized_crc_engine import pcrc_pkg::*; #(
   parameter int MAX_CRC_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   pcrc_req_if.sink              req_bus,
   pcrc_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Effective-width and shift-amount widths follow the largest width supported.
   localparam int WW = $clog2(MAX_CRC_WIDTH + 1);
   localparam int SW = $clog2(MAX_CRC_WIDTH);
   // Result arithmetic runs at least as wide as the output field.
   localparam int RW = (MAX_CRC_WIDTH > CRC_OUT_W) ? MAX_CRC_WIDTH : CRC_OUT_W;
   localparam logic [MAX_CRC_WIDTH-1:0] ALL_ONES = '1;
   // The running register carries at most 32 bits from one byte to the next.
   localparam logic [MAX_CRC_WIDTH-1:0] KEEP_MASK = MAX_CRC_WIDTH'(32'hFFFF_FFFF);

   // ------------------------------------------------------------------
   // Configuration registers. Writes land on the access phase of an APB
   // transfer; the port never inserts wait states.
   // ------------------------------------------------------------------
   logic [CFG_WIDTH_W-1:0] cfg_width_ff,   cfg_width_in;
   logic [31:0]            cfg_poly_ff,    cfg_poly_in;
   logic [31:0]            cfg_init_ff,    cfg_init_in;
   logic [31:0]            cfg_xor_ff,     cfg_xor_in;
   logic                   cfg_refin_ff,   cfg_refin_in;
   logic                   cfg_refout_ff,  cfg_refout_in;

   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_poly_in   = cfg_poly_ff;
      cfg_init_in   = cfg_init_ff;
      cfg_xor_in    = cfg_xor_ff;
      cfg_refin_in  = cfg_refin_ff;
      cfg_refout_in = cfg_refout_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CRC_WIDTH:      cfg_width_in  = csr_pwdata[CFG_WIDTH_W-1:0];
            REG_GENERATOR_POLY: cfg_poly_in   = csr_pwdata;
            REG_INITIAL_VALUE:  cfg_init_in   = csr_pwdata;
            REG_FINAL_XOR:      cfg_xor_in    = csr_pwdata;
            REG_REFLECT_INPUT:  cfg_refin_in  = csr_pwdata[0];
            REG_REFLECT_OUTPUT: cfg_refout_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read data is a plain decode of the stored register values.
   always_comb begin
      unique case (csr_index)
         REG_CRC_WIDTH:      csr_prdata = CSR_DATA_W'(cfg_width_ff);
         REG_GENERATOR_POLY: csr_prdata = cfg_poly_ff;
         REG_INITIAL_VALUE:  csr_prdata = cfg_init_ff;
         REG_FINAL_XOR:      csr_prdata = cfg_xor_ff;
         REG_REFLECT_INPUT:  csr_prdata = CSR_DATA_W'(cfg_refin_ff);
         REG_REFLECT_OUTPUT: csr_prdata = CSR_DATA_W'(cfg_refout_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RST_CRC_WIDTH;
         cfg_poly_ff   <= RST_GENERATOR_POLY;
         cfg_init_ff   <= RST_INITIAL_VALUE;
         cfg_xor_ff    <= RST_FINAL_XOR;
         cfg_refin_ff  <= RST_REFLECT_INPUT;
         cfg_refout_ff <= RST_REFLECT_OUTPUT;
      end else begin
         cfg_width_ff  <= cfg_width_in;
         cfg_poly_ff   <= cfg_poly_in;
         cfg_init_ff   <= cfg_init_in;
         cfg_xor_ff    <= cfg_xor_in;
         cfg_refin_ff  <= cfg_refin_in;
         cfg_refout_ff <= cfg_refout_in;
      end
   end

   // ------------------------------------------------------------------
   // Derived configuration. A width of zero acts as one, and anything above
   // MAX_CRC_WIDTH saturates. The fold runs on a left-aligned copy of the
   // register so the feedback tap is always the top bit; the shift amount
   // is the distance between the effective width and the datapath width.
   // ------------------------------------------------------------------
   logic [WW-1:0]            eff_width;
   logic [SW-1:0]            align_shift;
   logic [MAX_CRC_WIDTH-1:0] width_mask;
   logic [MAX_CRC_WIDTH-1:0] poly_aligned;

   always_comb begin
      if (cfg_width_ff == '0) begin
         eff_width = WW'(1);
      end else if (int'(cfg_width_ff) > MAX_CRC_WIDTH) begin
         eff_width = WW'(MAX_CRC_WIDTH);
      end else begin
         eff_width = WW'(cfg_width_ff);
      end
      align_shift  = SW'(MAX_CRC_WIDTH - int'(eff_width));
      width_mask   = ALL_ONES >> align_shift;
      poly_aligned = (MAX_CRC_WIDTH'(cfg_poly_ff) & width_mask) << align_shift;
   end

   // ------------------------------------------------------------------
   // Input stage: one beat of holding register in front of the fold.
   // ------------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic              fold_advance;   // result side can take a new beat
   logic              fold_fire;      // a byte is folded this cycle
   logic              req_take;

   assign fold_advance  = !rsp_bus.valid || rsp_bus.ready;
   assign fold_fire     = s1_valid_ff && fold_advance;
   assign req_bus.ready = !s1_valid_ff || fold_advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_bus.ready) begin
         s1_valid_in = req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_bus.data_byte;
         s1_last_ff <= req_bus.last_byte;
      end
   end

   // ------------------------------------------------------------------
   // Fold stage. The running CRC is kept right-aligned in normal form and
   // is masked to the current width before each fold. The first byte of a
   // message starts from the initial value instead. Eight polynomial steps
   // follow, feeding the byte in MSB first (or LSB first when input
   // reflection is on).
   // ------------------------------------------------------------------
   logic [MAX_CRC_WIDTH-1:0] crc_ff, crc_in;
   logic                     in_msg_ff, in_msg_in;
   logic [MAX_CRC_WIDTH-1:0] fold_start;
   logic [MAX_CRC_WIDTH-1:0] fold_acc;
   logic [MAX_CRC_WIDTH-1:0] fold_result;     // right-aligned
   logic [MAX_CRC_WIDTH-1:0] fold_reversed;   // reflected over the width
   logic [DATA_W-1:0]        feed_byte;
   logic                     feedback;

   always_comb begin
      if (in_msg_ff) begin
         fold_start = crc_ff & width_mask;
      end else begin
         fold_start = MAX_CRC_WIDTH'(cfg_init_ff) & width_mask;
      end
      feed_byte = cfg_refin_ff ? reverse_byte(s1_byte_ff) : s1_byte_ff;

      fold_acc = fold_start << align_shift;
      for (int i = 0; i < DATA_W; i++) begin
         feedback = fold_acc[MAX_CRC_WIDTH-1] ^ feed_byte[DATA_W-1-i];
         fold_acc = fold_acc << 1;
         if (feedback) begin
            fold_acc = fold_acc ^ poly_aligned;
         end
      end
      fold_result = fold_acc >> align_shift;

      // Reversing the left-aligned word puts the reflected width-bit value
      // straight into the low bits.
      for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
         fold_reversed[i] = fold_acc[MAX_CRC_WIDTH-1-i];
      end
   end

   always_comb begin
      crc_in    = crc_ff;
      in_msg_in = in_msg_ff;
      if (fold_fire) begin
         crc_in    = fold_result & KEEP_MASK;
         in_msg_in = !s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         in_msg_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         in_msg_ff <= in_msg_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register. It also acts as the output buffer: a finished CRC
   // may wait here while one more byte is taken into the input stage behind it.
   // ------------------------------------------------------------------
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CRC_OUT_W-1:0] rsp_crc_ff;
   logic [RW-1:0]        result_wide;

   always_comb begin
      if (cfg_refout_ff) begin
         result_wide = RW'(fold_reversed);
      end else begin
         result_wide = RW'(fold_result);
      end
      result_wide = (result_wide ^ RW'(cfg_xor_ff)) & RW'(width_mask);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fold_advance) begin
         rsp_valid_in = s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fold_fire && s1_last_ff) begin
         rsp_crc_ff <= result_wide[CRC_OUT_W-1:0];
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.crc_value = rsp_crc_ff;

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   // A folded last byte always produces a result beat and closes the message.
   `PCRC_ASSERT_NEXT(a_last_gives_result, clock, reset, fold_fire && s1_last_ff, rsp_valid_ff)
   `PCRC_ASSERT_NEXT(a_last_closes_msg, clock, reset, fold_fire && s1_last_ff, !in_msg_ff)
   // A byte held in the input stage while the fold stalls stays put and does not change.
   `PCRC_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !fold_advance, $stable(s1_byte_ff))
   `PCRC_ASSERT_NEXT(a_s1_stays, clock, reset, s1_valid_ff && !fold_advance, s1_valid_ff)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench import pcrc_pkg::*;;

   // The engine saturates the CRC width at this value; the predictor does the same.
   localparam int MAX_WIDTH = 32;

   // The run is ended by force after this many clock cycles.
   localparam int CYCLE_LIMIT = 200000;

   // Random phases, and the number of bytes offered in each of them.
   localparam int NUM_PHASES = 12;
   localparam int PHASE_BYTES = 120;

   // The receiver refuses results for this long when the hold-off is triggered.
   localparam int HOLD_CYCLES = 300;

   // Idle cycles after the last owed CRC, so that a byte without a result also passes through the engine.
   localparam int SETTLE_CYCLES = 6;

   // Well-known polynomials used as configuration presets.
   localparam logic [31:0] POLY_CRC32 = 32'h04C1_1DB7;
   localparam logic [31:0] POLY_ARC   = 32'h0000_8005;
   localparam logic [31:0] POLY_CCITT = 32'h0000_1021;
   localparam logic [31:0] POLY_DNP   = 32'h0000_3D65;

   // A row of the directed table either writes one register or offers one byte.
   // Where the finished CRC of a byte row is obvious it is typed into the row.
   // Every other result comes from the predictor.
   typedef enum logic {
      ROW_BYTE,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type csr;
      logic [31:0]   value;
      logic [7:0]    data;
      logic          is_last;
      logic          known;
      logic [31:0]   crc;
   } stim_row_type;

   localparam int NUM_ROWS = 42;

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pcrc_req_if req_if ();
   pcrc_rsp_if rsp_if ();

   parameterized_crc_engine #(
      .MAX_CRC_WIDTH(MAX_WIDTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_if),
      .rsp_bus    (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // The testbench's copy of the configuration registers.
   logic [CFG_WIDTH_W-1:0] cfg_width;
   logic [31:0]            cfg_poly;
   logic [31:0]            cfg_init;
   logic [31:0]            cfg_xorout;
   logic                   cfg_refin;
   logic                   cfg_refout;

   // The testbench's copy of the running CRC and of whether a message is open.
   logic [31:0] crc_state;
   logic        msg_open;

   // CRCs still owed by the engine, oldest first.
   logic [31:0] pending_crcs[$];

   int mismatch_count = 0;
   int cycle_count = 0;

   // Idle rates of both sides, in percent, set per phase by the stimulus.
   int send_idle_pct = 33;
   int recv_idle_pct = 61;

   // Each flip of hold_toggle starts one long hold-off in the receiver.
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   // Directed table. It starts with the reset configuration (the CRC-32 used by
   // Ethernet and zip), then walks through narrow, saturated and masked widths,
   // a polynomial of zero, wide register values and a change of settings in the
   // middle of an open message.
   stim_row_type directed_rows [0:NUM_ROWS-1] = '{
      // Single-byte messages and the standard check string under the reset setup.
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h00, 1'b1, 1'b1, 32'hD202_EF8D},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'hFF, 1'b1, 1'b1, 32'hFF00_0000},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h31, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h32, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h33, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h34, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h35, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h36, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h37, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h38, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h39, 1'b1, 1'b1, 32'hCBF4_3926},
      // 16-bit CCITT setup without any reflection.
      '{ROW_CSR, REG_CRC_WIDTH,      32'd16,      8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_GENERATOR_POLY, POLY_CCITT,  8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_INITIAL_VALUE,  32'hFFFF,    8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_FINAL_XOR,      32'h0,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_REFLECT_INPUT,  32'h0,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_REFLECT_OUTPUT, 32'h0,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h31, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h32, 1'b1, 1'b0, 32'h0},
      // A one-bit CRC with polynomial one is the parity of the message.
      '{ROW_CSR, REG_CRC_WIDTH,      32'd1,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_GENERATOR_POLY, 32'h1,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_INITIAL_VALUE,  32'h0,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h80, 1'b1, 1'b1, 32'h1},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h7F, 1'b1, 1'b1, 32'h1},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'hFF, 1'b1, 1'b1, 32'h0},
      // A width of zero behaves as a width of one.
      '{ROW_CSR, REG_CRC_WIDTH,      32'd0,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h01, 1'b1, 1'b1, 32'h1},
      // Width 63 saturates to 32; with a zero polynomial the preset just shifts.
      '{ROW_CSR, REG_CRC_WIDTH,      32'd63,      8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_GENERATOR_POLY, 32'h0,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_INITIAL_VALUE,  32'h1234_5678, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'hAB, 1'b1, 1'b1, 32'h3456_7800},
      // Bits above an 8-bit width are ignored in every register.
      '{ROW_CSR, REG_CRC_WIDTH,      32'd8,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_GENERATOR_POLY, 32'h107,     8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_INITIAL_VALUE,  32'hFFFF_FF00, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_FINAL_XOR,      32'hFFFF_FF00, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h00, 1'b1, 1'b1, 32'h0},
      // Reflected input with a plain output.
      '{ROW_CSR, REG_REFLECT_INPUT,  32'h1,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'hC5, 1'b1, 1'b0, 32'h0},
      // Settings changed while a message is open take effect on the next byte.
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h12, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_REFLECT_INPUT,  32'h0,       8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_CRC_WIDTH,      32'd12,      8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, REG_CRC_WIDTH, 32'h0, 8'h34, 1'b1, 1'b0, 32'h0}
   };

   // Free-running clock with a 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Watchdog. A correct run finishes far below the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** parameterized_crc_engine: FAILED **");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch: %s, got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   // Folds one byte into the copy of the CRC register and, on the last byte of a
   // message, hands back the finished CRC. The register is kept unreflected;
   // reflection applies to the byte on the way in and to the CRC on the way out.
   function automatic void fold_crc_byte(input logic [7:0] data, input logic is_last,
                                         output logic has_crc, output logic [31:0] crc);
      int unsigned w;
      logic [32:0] wide_mask;
      logic [31:0] mask;
      logic [31:0] poly;
      logic [31:0] state;
      logic [31:0] outv;
      logic [7:0]  bits;
      logic        top;

      w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
      wide_mask = (33'd1 << w) - 33'd1;
      mask = wide_mask[31:0];
      poly = cfg_poly & mask;
      if (!msg_open) begin
         crc_state = cfg_init & mask;
      end
      state = crc_state & mask;

      bits = data;
      if (cfg_refin) begin
         for (int i = 0; i < 8; i++) begin
            bits[i] = data[7-i];
         end
      end

      for (int i = 0; i < 8; i++) begin
         top = state[w-1] ^ bits[7-i];
         state = (state << 1) & mask;
         if (top) begin
            state = state ^ poly;
         end
      end
      crc_state = state;

      has_crc = is_last;
      crc = '0;
      if (!is_last) begin
         msg_open = 1'b1;
      end else begin
         msg_open = 1'b0;
         outv = state;
         if (cfg_refout) begin
            outv = '0;
            for (int i = 0; i < w; i++) begin
               outv[w-1-i] = state[i];
            end
         end
         crc = (outv ^ cfg_xorout) & mask;
      end
   endfunction

   // Offers one byte, with random idle cycles in front of it, and records the CRC
   // the engine owes once the byte has been taken. A typed-in CRC, where given,
   // replaces the predicted one; the predictor still runs to keep its state.
   task automatic push_byte(input logic [7:0] data, input logic is_last,
                            input logic known, input logic [31:0] typed_crc);
      logic        has_crc;
      logic [31:0] crc;

      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= data;
      req_if.last_byte <= is_last;
      do begin
         @(posedge clock);
      end while (!req_if.ready);

      fold_crc_byte(data, is_last, has_crc, crc);
      if (has_crc) begin
         pending_crcs.push_back(known ? typed_crc : crc);
      end
   endtask

   // Stops offering bytes and waits until every owed CRC has come back, then lets
   // the pipeline settle so that a byte without a result is also finished.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_crcs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register over the APB port, updates the local copy at the edge
   // that commits the write, then reads the register back and checks it.
   task automatic cfg_write(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] readback;

      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);

      case (idx)
         REG_CRC_WIDTH: begin
            cfg_width = value[CFG_WIDTH_W-1:0];
            readback = {{(32-CFG_WIDTH_W){1'b0}}, cfg_width};
         end
         REG_GENERATOR_POLY: begin
            cfg_poly = value;
            readback = cfg_poly;
         end
         REG_INITIAL_VALUE: begin
            cfg_init = value;
            readback = cfg_init;
         end
         REG_FINAL_XOR: begin
            cfg_xorout = value;
            readback = cfg_xorout;
         end
         REG_REFLECT_INPUT: begin
            cfg_refin = value[0];
            readback = {31'b0, cfg_refin};
         end
         default: begin
            cfg_refout = value[0];
            readback = {31'b0, cfg_refout};
         end
      endcase

      // Read back through the same port; psel stays high for the new setup cycle.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (csr_prdata !== readback) begin
         flag_mismatch($sformatf("readback of %s", idx.name()), csr_prdata, readback);
      end
      // The port goes idle before the next transfer may start.
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver. It refuses beats at the phase's idle rate, and for a long stretch
   // whenever the stimulus flips hold_toggle; the stretch is counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Every CRC beat is compared with the oldest owed CRC.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         if (pending_crcs.size() == 0) begin
            flag_mismatch("crc beat with nothing owed", rsp_if.crc_value, 32'h0);
         end else if (rsp_if.crc_value !== pending_crcs[0]) begin
            flag_mismatch("crc_value", rsp_if.crc_value, pending_crcs.pop_front());
         end else begin
            void'(pending_crcs.pop_front());
         end
      end
   end

   initial begin
      int          msg_len;
      int          sent;
      logic        paused;
      logic [7:0]  data;
      logic [5:0]  r_width;
      logic [31:0] r_poly;
      logic [31:0] r_init;
      logic [31:0] r_xorout;
      logic        r_refin;
      logic        r_refout;

      // Every input is known from time zero, and reset is held high from time zero until released.
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;

      cfg_width  = RST_CRC_WIDTH;
      cfg_poly   = RST_GENERATOR_POLY;
      cfg_init   = RST_INITIAL_VALUE;
      cfg_xorout = RST_FINAL_XOR;
      cfg_refin  = RST_REFLECT_INPUT;
      cfg_refout = RST_REFLECT_OUTPUT;
      crc_state  = '0;
      msg_open   = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Register rows wait until the engine has gone quiet.
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            drain_results();
            cfg_write(directed_rows[r].csr, directed_rows[r].value);
         end else begin
            push_byte(directed_rows[r].data, directed_rows[r].is_last,
                      directed_rows[r].known, directed_rows[r].crc);
         end
      end

      // Random part. The first third of the phases has a slow sender and a slower
      // receiver, the second third swaps the two rates, and the last third runs
      // without idle cycles. Each phase starts from a fresh configuration.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         send_idle_pct = (phase < NUM_PHASES / 3) ? 33 :
                         (phase < 2 * NUM_PHASES / 3) ? 61 : 0;
         recv_idle_pct = (phase < NUM_PHASES / 3) ? 61 :
                         (phase < 2 * NUM_PHASES / 3) ? 33 : 0;

         // Mostly catalogue setups; the rest are fully random, with the width
         // often pushed to zero, one, the maximum or into the saturated range.
         case ($urandom_range(4))
            0: begin
               r_width = 6'd32; r_poly = POLY_CRC32; r_init = 32'hFFFF_FFFF;
               r_xorout = 32'hFFFF_FFFF; r_refin = 1'b1; r_refout = 1'b1;
            end
            1: begin
               r_width = 6'd16; r_poly = POLY_ARC; r_init = 32'h0;
               r_xorout = 32'h0; r_refin = 1'b1; r_refout = 1'b1;
            end
            2: begin
               r_width = 6'd16; r_poly = POLY_CCITT; r_init = 32'hFFFF;
               r_xorout = 32'h0; r_refin = 1'b0; r_refout = 1'b0;
            end
            3: begin
               r_width = 6'd16; r_poly = POLY_DNP; r_init = 32'h0;
               r_xorout = 32'hFFFF; r_refin = 1'b1; r_refout = 1'b1;
            end
            default: begin
               case ($urandom_range(7))
                  0: r_width = 6'd0;
                  1: r_width = 6'd1;
                  2: r_width = 6'd32;
                  3: r_width = 6'd63;
                  4: r_width = 6'($urandom_range(33, 62));
                  default: r_width = 6'($urandom_range(2, 31));
               endcase
               r_poly   = $urandom;
               r_init   = $urandom;
               r_xorout = $urandom;
               r_refin  = 1'($urandom_range(1));
               r_refout = 1'($urandom_range(1));
            end
         endcase
         cfg_write(REG_CRC_WIDTH, {26'b0, r_width});
         cfg_write(REG_GENERATOR_POLY, r_poly);
         cfg_write(REG_INITIAL_VALUE, r_init);
         cfg_write(REG_FINAL_XOR, r_xorout);
         cfg_write(REG_REFLECT_INPUT, {31'b0, r_refin});
         cfg_write(REG_REFLECT_OUTPUT, {31'b0, r_refout});

         // In the first phase without idling the receiver stops for a long
         // stretch while bytes keep coming, so the engine must stall its input.
         if (phase == 2 * NUM_PHASES / 3) begin
            hold_toggle <= ~hold_toggle;
         end

         sent = 0;
         paused = 1'b0;
         while (sent < PHASE_BYTES) begin
            // Short messages dominate; now and then a long one.
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) :
                      $urandom_range(1, 8);
            for (int k = 0; k < msg_len; k++) begin
               case ($urandom_range(9))
                  0: data = 8'h00;
                  1: data = 8'hFF;
                  default: data = 8'($urandom_range(255));
               endcase
               push_byte(data, k == msg_len - 1, 1'b0, 32'h0);
               sent++;
            end
            // Once, the sender goes quiet until every owed CRC has come back.
            if (phase == NUM_PHASES / 2 && !paused && sent >= PHASE_BYTES / 2) begin
               paused = 1'b1;
               drain_results();
            end
         end
      end

      drain_results();
      if (pending_crcs.size() != 0) begin
         flag_mismatch("crc beats never delivered", 32'(pending_crcs.size()), 32'h0);
      end
      if (mismatch_count == 0) begin
         $display("** parameterized_crc_engine: PASSED **");
      end else begin
         $display("** parameterized_crc_engine: FAILED **");
      end
      $finish;
   end

endmodule
